[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CBA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication
`define CBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

[hw/rtl/cba_pkg.sv]
// ----------------------------------------------------------------------------
// cba_pkg
// Widths, codes and parameter defaults of the chunked bump allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cba_pkg;

  // Parameter defaults
  localparam int CHUNK_BYTES_DEF = 1024;
  localparam int MAX_CHUNKS_DEF  = 16;

  // Fixed field widths
  localparam int COMMAND_W     = 1;
  localparam int COUNT_W       = 11;
  localparam int ELEM_W        = 7;
  localparam int STATUS_W      = 2;
  localparam int CHUNK_INDEX_W = 4;
  localparam int BYTE_OFFSET_W = 11;
  // count * element_bytes, also wide enough for fill + size at the largest chunk
  localparam int SIZE_W        = 18;

  localparam logic [ELEM_W-1:0] ELEM_BYTES_RST = ELEM_W'(1);

  // Commands
  localparam logic [COMMAND_W-1:0] CMD_ALLOC       = 1'b0;
  localparam logic [COMMAND_W-1:0] CMD_RELEASE_ALL = 1'b1;

  // Result status
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_TOO_BIG   = 2'd1,
    ST_NO_CHUNKS = 2'd2
  } status_t;

endpackage

[hw/rtl/chunked_bump_allocator.sv]
// ----------------------------------------------------------------------------
// chunked_bump_allocator
// Bump-pointer allocator over a set of fixed-size chunks. Searches the open
// chunks newest first for room, else opens a new chunk if one is left.
// ----------------------------------------------------------------------------
//   channel | direction | handshake              | word
//   in      | input     | in_valid / in_ready    | command, element_count
//   out     | output    | out_valid / out_ready  | status, chunk_index, byte_offset,
//           |           |                        | opened_chunk
//   cfg     | input     | cfg_wr_en, no stall    | element_bytes
//
// Steps: a release-all goes through the emit state to the output register; an
// allocate goes through size, check and emit, visiting up to MAX_CHUNKS chunks
// in check (none for an oversized request or when no chunk is open): the fill
// levels sit in one memory with one registered read port, read one a cycle.
// One word is in flight at a time; in_ready is high only while idle.
// A finished result waits in the output register; a new word can be taken
// meanwhile, and its result waits until the output register is free.
// Reset (rst_n, synchronous) clears chunk count and control and sets the element
// size to one; the fill memory is not cleared, only open chunks are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chunked_bump_allocator #(
  parameter int CHUNK_BYTES = cba_pkg::CHUNK_BYTES_DEF,
  parameter int MAX_CHUNKS  = cba_pkg::MAX_CHUNKS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [cba_pkg::COMMAND_W-1:0]      in_command,
  input  logic [cba_pkg::COUNT_W-1:0]        in_element_count,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [cba_pkg::STATUS_W-1:0]       out_status,
  output logic [cba_pkg::CHUNK_INDEX_W-1:0]  out_chunk_index,
  output logic [cba_pkg::BYTE_OFFSET_W-1:0]  out_byte_offset,
  output logic                               out_opened_chunk,
  // configuration
  input  logic                               cfg_wr_en,
  input  logic [cba_pkg::ELEM_W-1:0]         cfg_wr_data
);

  localparam int IDX_W  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int OPEN_W = $clog2(MAX_CHUNKS + 1);
  localparam int FILL_W = $clog2(CHUNK_BYTES + 1);
  localparam int SIZE_W = cba_pkg::SIZE_W;

  localparam logic [SIZE_W-1:0] CHUNK_LIMIT = SIZE_W'(CHUNK_BYTES);
  localparam logic [OPEN_W-1:0] OPEN_LIMIT  = OPEN_W'(MAX_CHUNKS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SIZE,
    S_CHECK,
    S_EMIT
  } state_t;

  // Fill level memory, one write and one registered read port
  logic [FILL_W-1:0] fill_mem [MAX_CHUNKS];
  logic [FILL_W-1:0] rd_data_r;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [FILL_W-1:0] mem_wdata;

  // Control and datapath registers
  state_t                            state_r, state_nxt;
  logic [cba_pkg::ELEM_W-1:0]        elem_bytes_r, elem_bytes_nxt;
  logic [OPEN_W-1:0]                 chunks_open_r, chunks_open_nxt;
  logic [SIZE_W-1:0]                 size_r, size_nxt;
  logic [IDX_W-1:0]                  ptr_r, ptr_nxt;

  // Pending result
  cba_pkg::status_t                  res_status_r, res_status_nxt;
  logic [cba_pkg::CHUNK_INDEX_W-1:0] res_index_r, res_index_nxt;
  logic [cba_pkg::BYTE_OFFSET_W-1:0] res_offset_r, res_offset_nxt;
  logic                              res_opened_r, res_opened_nxt;

  // Output register
  logic                              out_valid_r, out_valid_nxt;
  cba_pkg::status_t                  out_status_r, out_status_nxt;
  logic [cba_pkg::CHUNK_INDEX_W-1:0] out_index_r, out_index_nxt;
  logic [cba_pkg::BYTE_OFFSET_W-1:0] out_offset_r, out_offset_nxt;
  logic                              out_opened_r, out_opened_nxt;

  logic              in_take;
  logic [SIZE_W-1:0] fit_sum;
  logic              fits;
  logic [OPEN_W-1:0] top_open;

  assign in_ready = (state_r == S_IDLE);
  assign in_take  = in_valid && in_ready;

  // Shared compare: visited fill plus request against the chunk size
  assign fit_sum  = SIZE_W'(rd_data_r) + size_r;
  assign fits     = (fit_sum <= CHUNK_LIMIT);
  assign top_open = chunks_open_r - OPEN_W'(1);

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    elem_bytes_nxt  = elem_bytes_r;
    chunks_open_nxt = chunks_open_r;
    size_nxt        = size_r;
    ptr_nxt         = ptr_r;
    res_status_nxt  = res_status_r;
    res_index_nxt   = res_index_r;
    res_offset_nxt  = res_offset_r;
    res_opened_nxt  = res_opened_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_index_nxt   = out_index_r;
    out_offset_nxt  = out_offset_r;
    out_opened_nxt  = out_opened_r;
    rd_addr         = ptr_r;
    mem_we          = 1'b0;
    mem_waddr       = ptr_r;
    mem_wdata       = rd_data_r;

    if (cfg_wr_en) begin
      elem_bytes_nxt = cfg_wr_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          res_status_nxt = cba_pkg::ST_OK;
          res_index_nxt  = '0;
          res_offset_nxt = '0;
          res_opened_nxt = 1'b0;
          if (in_command == cba_pkg::CMD_RELEASE_ALL) begin
            chunks_open_nxt = '0;
            state_nxt       = S_EMIT;
          end else begin
            size_nxt  = SIZE_W'(in_element_count) * SIZE_W'(elem_bytes_r);
            state_nxt = S_SIZE;
          end
        end
      end

      S_SIZE: begin
        priority if (size_r > CHUNK_LIMIT) begin
          res_status_nxt = cba_pkg::ST_TOO_BIG;
          state_nxt      = S_EMIT;
        end else if (chunks_open_r == '0) begin
          // first chunk opens with the whole request
          mem_we          = 1'b1;
          mem_waddr       = '0;
          mem_wdata       = FILL_W'(size_r);
          res_opened_nxt  = 1'b1;
          chunks_open_nxt = OPEN_W'(1);
          state_nxt       = S_EMIT;
        end else begin
          // start at the newest open chunk
          ptr_nxt   = IDX_W'(top_open);
          rd_addr   = IDX_W'(top_open);
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        priority if (fits) begin
          mem_we         = 1'b1;
          mem_waddr      = ptr_r;
          mem_wdata      = FILL_W'(fit_sum);
          res_index_nxt  = cba_pkg::CHUNK_INDEX_W'(ptr_r);
          res_offset_nxt = cba_pkg::BYTE_OFFSET_W'(rd_data_r);
          state_nxt      = S_EMIT;
        end else if (ptr_r != '0) begin
          ptr_nxt = ptr_r - IDX_W'(1);
          rd_addr = ptr_r - IDX_W'(1);
        end else if (chunks_open_r >= OPEN_LIMIT) begin
          res_status_nxt = cba_pkg::ST_NO_CHUNKS;
          state_nxt      = S_EMIT;
        end else begin
          // no room anywhere: open the next chunk
          mem_we          = 1'b1;
          mem_waddr       = IDX_W'(chunks_open_r);
          mem_wdata       = FILL_W'(size_r);
          res_index_nxt   = cba_pkg::CHUNK_INDEX_W'(chunks_open_r);
          res_opened_nxt  = 1'b1;
          chunks_open_nxt = chunks_open_r + OPEN_W'(1);
          state_nxt       = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_index_nxt  = res_index_r;
          out_offset_nxt = res_offset_r;
          out_opened_nxt = res_opened_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      elem_bytes_r  <= cba_pkg::ELEM_BYTES_RST;
      chunks_open_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      elem_bytes_r  <= elem_bytes_nxt;
      chunks_open_r <= chunks_open_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    size_r       <= size_nxt;
    ptr_r        <= ptr_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    res_offset_r <= res_offset_nxt;
    res_opened_r <= res_opened_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_offset_r <= out_offset_nxt;
    out_opened_r <= out_opened_nxt;
  end

  // Fill memory write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      fill_mem[mem_waddr] <= mem_wdata;
    end
  end

  // Fill memory read port
  always_ff @(posedge clk) begin
    rd_data_r <= fill_mem[rd_addr];
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_chunk_index  = out_index_r;
  assign out_byte_offset  = out_offset_r;
  assign out_opened_chunk = out_opened_r;

endmodule

[hw/rtl/cba_checker.sv]
// ----------------------------------------------------------------------------
// cba_checker
// Port-level checks of the chunked bump allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cba_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [cba_pkg::STATUS_W-1:0]       out_status,
  input logic [cba_pkg::CHUNK_INDEX_W-1:0]  out_chunk_index,
  input logic [cba_pkg::BYTE_OFFSET_W-1:0]  out_byte_offset,
  input logic                               out_opened_chunk
);

  // A stalled result word stays valid and keeps its byte offset
  `CBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte_offset))

  // One word at a time: ready drops after a take
  `CBA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // Only defined status codes
  `CBA_ASSERT_IMPL(a_status_code, out_valid, out_status <= cba_pkg::ST_NO_CHUNKS)

  // Failed requests carry no region
  `CBA_ASSERT_IMPL(a_fail_zero, out_valid && out_status != cba_pkg::ST_OK, out_chunk_index == '0 && out_byte_offset == '0 && !out_opened_chunk)

  // A freshly opened chunk grants from its start
  `CBA_ASSERT_IMPL(a_open_at_zero, out_valid && out_opened_chunk, out_byte_offset == '0)

endmodule

bind chunked_bump_allocator cba_checker u_cba_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_chunk_index  (out_chunk_index),
  .out_byte_offset  (out_byte_offset),
  .out_opened_chunk (out_opened_chunk)
);

[verif/tb_chunked_bump_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chunked_bump_allocator
// Self-checking bench for the chunked bump allocator. A queue of request words
// is driven in random bursts; every accepted word runs through a local model
// of the chunk fill levels, and the grant it predicts is checked against the
// result channel, stalled in free, coin-flip or pattern modes. The element size is
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------

module tb_chunked_bump_allocator;

  localparam int          CHUNK_BYTES  = cba_pkg::CHUNK_BYTES_DEF;
  localparam int          MAX_CHUNKS   = cba_pkg::MAX_CHUNKS_DEF;
  localparam int          PHASE_WORDS  = 200;
  localparam int          DRAIN_CYCLES = 40;
  localparam int unsigned TIMEOUT_NS   = 5_000_000;

  typedef struct packed {
    logic [cba_pkg::COMMAND_W-1:0] command;
    logic [cba_pkg::COUNT_W-1:0]   count;
  } alloc_word_t;

  typedef struct packed {
    cba_pkg::status_t                   status;
    logic [cba_pkg::CHUNK_INDEX_W-1:0]  chunk;
    logic [cba_pkg::BYTE_OFFSET_W-1:0]  offset;
    logic                               opened;
  } grant_t;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_PATTERN} rx_mode_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [cba_pkg::COMMAND_W-1:0]     in_command = cba_pkg::CMD_ALLOC;
  logic [cba_pkg::COUNT_W-1:0]       in_element_count = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [cba_pkg::STATUS_W-1:0]      out_status;
  logic [cba_pkg::CHUNK_INDEX_W-1:0] out_chunk_index;
  logic [cba_pkg::BYTE_OFFSET_W-1:0] out_byte_offset;
  logic                              out_opened_chunk;
  logic                              cfg_wr_en = 1'b0;
  logic [cba_pkg::ELEM_W-1:0]        cfg_wr_data = '0;

  // allocator model state
  logic [cba_pkg::BYTE_OFFSET_W-1:0] fill_bytes [MAX_CHUNKS];
  logic [4:0]                        open_chunks = '0;
  logic [cba_pkg::ELEM_W-1:0]        elem_bytes_m = cba_pkg::ELEM_BYTES_RST;

  alloc_word_t word_q [$];
  grant_t      grant_q [$];
  int          queued_n = 0;
  int          accepted_n = 0;
  int          err_count = 0;
  bit          word_taken = 1'b0;

  // sender burst state
  int burst_left = 0;
  int gap_left = 0;

  // receiver stall state
  rx_mode_t    rx_mode = RX_FREE;
  int          rx_left = 0;
  logic [15:0] rx_pat = 16'hFFFF;
  int          rx_pos = 0;

  chunked_bump_allocator u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_element_count (in_element_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_chunk_index  (out_chunk_index),
    .out_byte_offset  (out_byte_offset),
    .out_opened_chunk (out_opened_chunk),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Grant for one request word; updates the model fill levels
  function automatic grant_t predict_grant(alloc_word_t w);
    grant_t                         g;
    logic [cba_pkg::SIZE_W-1:0]     need;
    int                             c;
    bit                             placed;
    g = '{status: cba_pkg::ST_OK, chunk: '0, offset: '0, opened: 1'b0};
    placed = 1'b0;
    if (w.command == cba_pkg::CMD_RELEASE_ALL) begin
      open_chunks = '0;
      return g;
    end
    need = cba_pkg::SIZE_W'(w.count) * cba_pkg::SIZE_W'(elem_bytes_m);
    if (int'(need) > CHUNK_BYTES) begin
      g.status = cba_pkg::ST_TOO_BIG;
      return g;
    end
    // newest open chunk first
    for (c = int'(open_chunks) - 1; c >= 0 && !placed; c--) begin
      if (int'(fill_bytes[c]) + int'(need) <= CHUNK_BYTES) begin
        g.chunk = cba_pkg::CHUNK_INDEX_W'(c);
        g.offset = fill_bytes[c];
        fill_bytes[c] = fill_bytes[c] + cba_pkg::BYTE_OFFSET_W'(need);
        placed = 1'b1;
      end
    end
    if (placed)
      return g;
    if (int'(open_chunks) >= MAX_CHUNKS) begin
      g.status = cba_pkg::ST_NO_CHUNKS;
      return g;
    end
    fill_bytes[open_chunks] = cba_pkg::BYTE_OFFSET_W'(need);
    g.chunk = cba_pkg::CHUNK_INDEX_W'(open_chunks);
    g.opened = 1'b1;
    open_chunks = open_chunks + 5'd1;
    return g;
  endfunction

  task automatic queue_word(logic [cba_pkg::COMMAND_W-1:0] cmd, int cnt);
    word_q.push_back('{command: cmd, count: cba_pkg::COUNT_W'(cnt)});
    queued_n++;
  endtask

  // Mostly requests that fit, with boundary sizes, oversized noise and releases
  task automatic queue_random(int n);
    int r;
    int lim;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      lim = (elem_bytes_m == 0) ? 2047 : CHUNK_BYTES / int'(elem_bytes_m);
      if (r < 3)
        queue_word(cba_pkg::CMD_RELEASE_ALL, $urandom_range(0, 2047));
      else if (r < 10)
        queue_word(cba_pkg::CMD_ALLOC, $urandom_range(0, 2047));
      else if (r < 16)
        queue_word(cba_pkg::CMD_ALLOC, lim + $urandom_range(0, 1));
      else if (r < 45)
        queue_word(cba_pkg::CMD_ALLOC, $urandom_range(0, lim));
      else
        queue_word(cba_pkg::CMD_ALLOC, $urandom_range(0, lim / 4));
    end
  endtask

  // Block idle: every word accepted and answered, plus pipeline slack
  task automatic wait_idle();
    while (accepted_n != queued_n || grant_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_elem_bytes(logic [cba_pkg::ELEM_W-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    elem_bytes_m = v;
  endtask

  task automatic report_mismatch(string what, grant_t want, grant_t got);
    err_count++;
    if (err_count <= 10)
      $display("%0t %s: exp st=%0d idx=%0d off=%0d new=%0d, got st=%0d idx=%0d off=%0d new=%0d",
               $realtime, what, want.status, want.chunk, want.offset, want.opened,
               got.status, got.chunk, got.offset, got.opened);
  endtask

  // Driver: words leave the queue in bursts separated by random gaps
  always @(negedge clk) begin
    alloc_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (word_q.size() != 0) begin
        w = word_q.pop_front();
        in_valid <= 1'b1;
        in_command <= w.command;
        in_element_count <= w.count;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 32);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Accepted words go through the model
  always @(posedge clk) begin
    word_taken = rst_n && in_valid && in_ready;
    if (word_taken) begin
      grant_q.push_back(predict_grant('{command: in_command, count: in_element_count}));
      accepted_n++;
    end
  end

  // Receiver: free-running, coin-flip or fixed-pattern stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 2));
        rx_left <= $urandom_range(20, 200);
        rx_pat <= 16'($urandom) | 16'h0001;
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_FREE:    out_ready <= 1'b1;
        RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
        default: begin
          out_ready <= rx_pat[rx_pos];
          rx_pos <= (rx_pos + 1) % 16;
        end
      endcase
    end
  end

  // Monitor: each result against the oldest predicted grant
  always @(posedge clk) begin
    grant_t got;
    grant_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{status: cba_pkg::status_t'(out_status), chunk: out_chunk_index,
              offset: out_byte_offset, opened: out_opened_chunk};
      if (grant_q.size() == 0) begin
        report_mismatch("result with none pending", '0, got);
      end else begin
        want = grant_q.pop_front();
        if (out_status !== want.status || out_chunk_index !== want.chunk ||
            out_byte_offset !== want.offset || out_opened_chunk !== want.opened)
          report_mismatch("result mismatch", want, got);
      end
    end
  end

  initial begin
    logic [cba_pkg::ELEM_W-1:0] settings [6];
    settings = '{7'd64, 7'd127, 7'd0, 7'd1, 7'd5, 7'd1};
    settings[5] = cba_pkg::ELEM_W'($urandom_range(1, 64));
    foreach (fill_bytes[i])
      fill_bytes[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset element size
    queue_word(cba_pkg::CMD_ALLOC, 0);          // zero size opens the first chunk
    queue_word(cba_pkg::CMD_ALLOC, 1024);       // exactly one full chunk
    queue_word(cba_pkg::CMD_ALLOC, 1025);       // just over a chunk
    queue_word(cba_pkg::CMD_ALLOC, 2047);       // all count bits set
    queue_word(cba_pkg::CMD_ALLOC, 1);
    queue_word(cba_pkg::CMD_RELEASE_ALL, 0);
    for (int i = 0; i < MAX_CHUNKS; i++)
      queue_word(cba_pkg::CMD_ALLOC, 1024);     // fill every chunk
    queue_word(cba_pkg::CMD_ALLOC, 1);          // out of chunks
    queue_word(cba_pkg::CMD_ALLOC, 0);          // zero size still fits a full chunk
    queue_word(cba_pkg::CMD_RELEASE_ALL, 2047);
    wait_idle();

    // Random phases, one element size each, sender paused in between
    foreach (settings[p]) begin
      write_elem_bytes(settings[p]);
      queue_random(PHASE_WORDS);
      wait_idle();
    end

    if (err_count == 0)
      $display("tb_chunked_bump_allocator: done, clean");
    else
      $display("tb_chunked_bump_allocator: done, errors");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_chunked_bump_allocator: done, errors");
    $finish;
  end

endmodule
